[hdl/aeo_pkg.sv]
// ----------------------------------------------------------------------------
// aeo_pkg
// Shared widths, register indexes and line store word type for the alpha
// edge outline block.
// ----------------------------------------------------------------------------
package aeo_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned ALPHA_BITS     = 8;
  localparam int unsigned COLOR_BITS     = 32;
  localparam int unsigned WIDTH_BITS     = 11;
  localparam int unsigned HEIGHT_BITS    = 13;
  localparam int unsigned LS_BITS        = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAIN_COLOR   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_COLOR   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [LS_BITS-1:0]    ls_word_t;

endpackage

[hdl/aeo_line_store.sv]
// ----------------------------------------------------------------------------
// aeo_line_store
// Opacity line store: one write port, two registered read ports, with the
// write of the same edge forwarded to a read of the same entry.
// ----------------------------------------------------------------------------
module aeo_line_store
  import aeo_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  ls_word_t      wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output ls_word_t      rd_data0,
  output ls_word_t      rd_data1
);

  ls_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= (wr_en && (wr_addr == rd_addr0)) ? wr_data : mem[rd_addr0];
      rd_data1 <= (wr_en && (wr_addr == rd_addr1)) ? wr_data : mem[rd_addr1];
    end
  end

endmodule

[hdl/alpha_edge_outline_top.sv]
// ----------------------------------------------------------------------------
// alpha_edge_outline_top
// One-pixel outline of the opaque parts of a frame, streamed in raster order.
// ----------------------------------------------------------------------------
// An accepted item is registered in the working stage with its line store
// data; results leave through the single output register. Throughput: one
// item per cycle above the last row while out_stall is low. On the last row
// an item gives up to two results, the final one three; the input then stalls.
// Reset clears counters, flags and valid state; the line store is not cleared.
// ----------------------------------------------------------------------------
module alpha_edge_outline_top
  import aeo_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ALPHA_BITS-1:0]     alpha,
  output logic                      out_valid,
  input  logic                      out_stall,
  output color_t                    color,
  output logic                      last_in_run,
  output logic                      end_of_frame
);

  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  color_t                 main_color;
  color_t                 edge_color;
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [EW-1:0]          eff_w;
  logic [EH-1:0]          eff_h;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [EW-1:0] col_p1;
  logic [EH-1:0] row_p1;
  logic          last_col;
  logic          last_row;
  logic          accept;
  logic [CW-1:0] rd_addr1;

  logic          b_valid;
  logic [2:0]    b_pend;
  logic          b_a;
  logic [CW-1:0] b_col;
  logic          b_c_gt0;
  logic          b_c_ge2;
  logic          b_wrap;
  logic          b_r_gt0;
  logic          b_r_ge2;
  logic [2:0]    lf;

  ls_word_t rd_data0;
  ls_word_t rd_data1;
  logic     up1, up2, right;
  logic     mem_we;
  ls_word_t mem_wdata;

  color_t     col0, col1, col2;
  color_t     res_color;
  logic       res_eof;
  logic [2:0] rem;
  logic       out_free;
  logic       out_load;
  logic       done;
  logic       restart;

  function automatic color_t pick(logic centre, logic neigh, color_t mc, color_t ec);
    color_t v;
    v = '0;
    if (centre) v = mc;
    else if (neigh) v = ec;
    return v;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      main_color   <= '0;
      edge_color   <= '0;
      image_width  <= WIDTH_BITS'(1);
      image_height <= HEIGHT_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAIN_COLOR:   main_color   <= cfg_data;
        REG_EDGE_COLOR:   edge_color   <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_write &&
                   ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  always_comb begin
    if (image_width == '0) eff_w = EW'(1);
    else if (32'(image_width) > MAX_WIDTH) eff_w = EW'(MAX_WIDTH);
    else eff_w = EW'(image_width);
    if (image_height == '0) eff_h = EH'(1);
    else if (32'(image_height) > MAX_HEIGHT) eff_h = EH'(MAX_HEIGHT);
    else eff_h = EH'(image_height);
  end

  // position of the arriving item
  assign col_p1   = EW'(col) + EW'(1);
  assign row_p1   = EH'(row) + EH'(1);
  assign last_col = (col_p1 == eff_w);
  assign last_row = (row_p1 == eff_h);
  assign accept   = in_valid && !in_stall;
  assign rd_addr1 = last_col ? col : col_p1[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row_p1[RW-1:0];
      end else begin
        col <= col_p1[CW-1:0];
      end
    end
  end

  aeo_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (b_col),
    .wr_data  (mem_wdata),
    .rd_en    (accept),
    .rd_addr0 (col),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // working stage: item with its line store data
  always_ff @(posedge clk) begin
    if (accept) begin
      b_a     <= (alpha != '0);
      b_col   <= col;
      b_c_gt0 <= (col != '0);
      b_c_ge2 <= (EW'(col) >= EW'(2));
      b_wrap  <= last_col;
      b_r_gt0 <= (row != '0);
      b_r_ge2 <= (EH'(row) >= EH'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_pend  <= '0;
    end else if (accept) begin
      b_valid <= 1'b1;
      b_pend  <= {last_row && last_col, last_row && (col != '0), row != '0};
    end else begin
      if (done) b_valid <= 1'b0;
      if (out_load) b_pend <= rem;
    end
  end

  assign up1   = rd_data0[0];
  assign up2   = rd_data0[1];
  assign right = rd_data1[0];

  always_comb begin
    col0 = pick(up1, (b_c_gt0 & lf[1]) | (!b_wrap & right) | (b_r_ge2 & up2) | b_a,
                main_color, edge_color);
    col1 = pick(lf[0], (b_c_ge2 & lf[2]) | b_a | (b_r_gt0 & lf[1]),
                main_color, edge_color);
    col2 = pick(b_a, (b_c_gt0 & lf[0]) | (b_r_gt0 & up1), main_color, edge_color);
  end

  always_comb begin
    res_color = col2;
    res_eof   = 1'b1;
    rem       = '0;
    if (b_pend[0]) begin
      res_color = col0;
      res_eof   = 1'b0;
      rem       = b_pend & 3'b110;
    end else if (b_pend[1]) begin
      res_color = col1;
      res_eof   = 1'b0;
      rem       = b_pend & 3'b100;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign out_load  = b_valid && (b_pend != '0) && out_free;
  assign done      = b_valid && ((b_pend == '0) || (out_load && (rem == '0)));
  assign in_stall  = b_valid && !done;
  assign mem_we    = done;
  assign mem_wdata = {up1, b_a};

  // left flags advance as each item retires
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      lf <= '0;
    end else if (done) begin
      lf <= b_wrap ? 3'b000 : {lf[0], up1, b_a};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      color        <= res_color;
      last_in_run  <= (rem == '0);
      end_of_frame <= res_eof;
    end
  end

endmodule

[hdl/aeo_checker.sv]
// ----------------------------------------------------------------------------
// aeo_checker
// Port-level checks on the alpha edge outline block, bound to the top level.
// ----------------------------------------------------------------------------
module aeo_checker
  import aeo_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   in_stall,
  input logic   out_valid,
  input logic   out_stall,
  input color_t color,
  input logic   last_in_run,
  input logic   end_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(color) &&
                               $stable(last_in_run) && $stable(end_of_frame))
    else $error("output item changed while stalled");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> last_in_run)
    else $error("frame end not on last result of its item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> out_valid)
    else $error("input stalled with no result moving out");

endmodule

bind alpha_edge_outline_top aeo_checker u_aeo_checker (.*);
